// File: rtl/ipv4fd_pkg.sv
// ipv4fd_pkg: shared types and constants for the IPv4 forwarding decision block.
// Holds the command and result beat structs, table entry layouts and status codes.
// No dependencies.
package ipv4fd_pkg;

	// Default sizing handed to the top level parameters
	localparam int DEF_ROUTE_ENTRIES = 256;
	localparam int DEF_ARP_ENTRIES   = 64;
	localparam int DEF_NUM_PORTS     = 4;

	localparam int CFG_IDX_W = 2;

	// Command modes
	localparam logic [1:0] MODE_ROUTE = 2'd0;
	localparam logic [1:0] MODE_ARP   = 2'd1;
	localparam logic [1:0] MODE_FWD   = 2'd2;

	// Result status codes
	localparam logic [2:0] ST_FORWARD       = 3'd0;
	localparam logic [2:0] ST_ECHO          = 3'd1;
	localparam logic [2:0] ST_TIME_EXCEEDED = 3'd2;
	localparam logic [2:0] ST_UNREACHABLE   = 3'd3;
	localparam logic [2:0] ST_ARP_MISS      = 3'd4;
	localparam logic [2:0] ST_DROP          = 3'd5;
	localparam logic [2:0] ST_LOADED        = 3'd6;
	localparam logic [2:0] ST_FULL          = 3'd7;

	localparam logic [7:0] ICMP_PROTO        = 8'd1;
	localparam logic [7:0] ICMP_ECHO_REQUEST = 8'd8;

	typedef struct packed {
		logic [1:0]  mode;
		logic [31:0] address;
		logic [31:0] mask;
		logic [31:0] hop_addr;
		logic [1:0]  route_port;
		logic [47:0] mac_addr;
		logic [1:0]  in_port;
		logic [7:0]  ttl_in;
		logic [7:0]  protocol;
		logic [7:0]  icmp_kind;
		logic        header_ok;
	} cmd_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [1:0]  out_port;
		logic [31:0] hop_ip;
		logic [47:0] hop_mac;
		logic [7:0]  ttl_out;
	} result_t;

	typedef struct packed {
		logic [31:0] prefix;
		logic [31:0] mask;
		logic [31:0] hop;
		logic [1:0]  iface;
	} route_ent_t;

	typedef struct packed {
		logic [31:0] ip;
		logic [47:0] mac;
	} arp_ent_t;

endpackage

// File: rtl/ipv4_forwarding_decision_top.sv
// ipv4_forwarding_decision_top: route table, ARP cache and forwarding decision sequencer.
// Depends on ipv4fd_pkg for beat structs, entry layouts and status codes.
//
// Usage:
//  - Command channel: drive cmd and raise start; a beat is taken at a rising edge with
//    start high and busy low. busy drops in the cycle the result beat is issued.
//  - Result channel: done pulses for exactly one cycle with the result beat on result.
//    The receiver cannot stall; a result must be captured in its done cycle.
//  - Config channel: cfg_valid/cfg_ready with cfg_index selecting port0_ip..port3_ip.
//    cfg_ready is high whenever the block is idle.
//  - Timing: table loads, mode three and early decisions (echo, bad header, TTL)
//    raise done from the check state that follows the accepting edge. A forward lookup
//    first reads the route table one entry per cycle through its single memory read port,
//    then the ARP cache the same way, prefix and next-hop compares sharing one comparator;
//    done rises on a route miss, the first ARP match, or the end of the ARP scan.
//  - Commands: the next command may be accepted in the cycle done is high; none is
//    taken while a load or lookup is in progress.
//  - Reset: clears interface addresses, table fill counts and the sequencer. Table
//    contents are not cleared; only entries below the fill counts are ever used.
module ipv4_forwarding_decision_top
	import ipv4fd_pkg::*;
#(
	parameter int ROUTE_ENTRIES = DEF_ROUTE_ENTRIES,
	parameter int ARP_ENTRIES   = DEF_ARP_ENTRIES,
	parameter int NUM_PORTS     = DEF_NUM_PORTS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  cmd_t                 cmd,
	output logic                 done,
	output result_t              result,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]          cfg_data
);

	// Table index and count widths; counts must hold the full depth itself
	localparam int RAW = (ROUTE_ENTRIES > 1) ? $clog2(ROUTE_ENTRIES) : 1;
	localparam int AAW = (ARP_ENTRIES > 1) ? $clog2(ARP_ENTRIES) : 1;
	localparam int RCW = $clog2(ROUTE_ENTRIES + 1);
	localparam int ACW = $clog2(ARP_ENTRIES + 1);
	localparam int SIW = (RCW > ACW) ? RCW : ACW;
	localparam int PW  = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;

	// Sequencer states
	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_CHECK = 2'd1;
	localparam logic [1:0] S_RSCAN = 2'd2;
	localparam logic [1:0] S_ASCAN = 2'd3;

	logic [1:0]     state_q;
	cmd_t           cmd_q;
	logic [31:0]    port_ip_q [NUM_PORTS];
	logic [RCW-1:0] route_cnt_q;
	logic [ACW-1:0] arp_cnt_q;
	logic [SIW-1:0] scan_idx_q;
	logic           rd_vld_s1;
	route_ent_t     route_rd_s1;
	arp_ent_t       arp_rd_s1;
	logic           found_q;
	logic [31:0]    best_mask_q;
	logic [31:0]    best_hop_q;
	logic [1:0]     best_iface_q;
	logic           done_q;
	result_t        result_q;

	route_ent_t     route_mem [ROUTE_ENTRIES];
	arp_ent_t       arp_mem [ARP_ENTRIES];

	logic           route_full;
	logic           arp_full;
	logic           route_wr;
	logic           arp_wr;
	logic           route_issue;
	logic           arp_issue;
	logic           echo_hit;
	logic [31:0]    cmp_a;
	logic [31:0]    cmp_b;
	logic           cmp_eq;
	logic           mask_better;

	function automatic result_t mk_result(logic [2:0] st, logic [1:0] port,
			logic [31:0] hop, logic [47:0] mac, logic [7:0] ttl);
		result_t r;
		r.status   = st;
		r.out_port = port;
		r.hop_ip   = hop;
		r.hop_mac  = mac;
		r.ttl_out  = ttl;
		return r;
	endfunction

	assign busy      = (state_q != S_IDLE);
	assign cfg_ready = !busy;
	assign done      = done_q;
	assign result    = result_q;

	assign route_full = (route_cnt_q == RCW'(ROUTE_ENTRIES));
	assign arp_full   = (arp_cnt_q == ACW'(ARP_ENTRIES));
	assign route_wr   = (state_q == S_CHECK) && (cmd_q.mode == MODE_ROUTE) && !route_full;
	assign arp_wr     = (state_q == S_CHECK) && (cmd_q.mode == MODE_ARP) && !arp_full;

	// Issue one table read per cycle until the fill count is reached
	assign route_issue = (state_q == S_RSCAN) && (scan_idx_q < SIW'(route_cnt_q));
	assign arp_issue   = (state_q == S_ASCAN) && (scan_idx_q < SIW'(arp_cnt_q));

	// Echo request aimed at the arrival interface's own address
	assign echo_hit = (32'(cmd_q.in_port) < NUM_PORTS)
		&& (port_ip_q[cmd_q.in_port[PW-1:0]] == cmd_q.address)
		&& (cmd_q.protocol == ICMP_PROTO)
		&& (cmd_q.icmp_kind == ICMP_ECHO_REQUEST);

	// Shared equality unit: prefix match during the route scan, next-hop match in ARP scan
	assign cmp_a  = (state_q == S_ASCAN) ? arp_rd_s1.ip : (cmd_q.address & route_rd_s1.mask);
	assign cmp_b  = (state_q == S_ASCAN) ? best_hop_q : route_rd_s1.prefix;
	assign cmp_eq = (cmp_a == cmp_b);

	// Strictly longer mask wins, so ties keep the earlier route
	assign mask_better = !found_q || (route_rd_s1.mask > best_mask_q);

	// Interface address registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int p = 0; p < NUM_PORTS; p++) begin
				port_ip_q[p] <= '0;
			end
		end else if (cfg_valid && cfg_ready && (32'(cfg_index) < NUM_PORTS)) begin
			port_ip_q[cfg_index[PW-1:0]] <= cfg_data;
		end
	end

	// Route table memory: append at the fill count, registered read at the scan index
	always_ff @(posedge clk) begin
		if (route_wr) begin
			route_mem[route_cnt_q[RAW-1:0]] <= '{prefix: cmd_q.address, mask: cmd_q.mask,
				hop: cmd_q.hop_addr, iface: cmd_q.route_port};
		end
		route_rd_s1 <= route_mem[scan_idx_q[RAW-1:0]];
	end

	// ARP cache memory
	always_ff @(posedge clk) begin
		if (arp_wr) begin
			arp_mem[arp_cnt_q[AAW-1:0]] <= '{ip: cmd_q.address, mac: cmd_q.mac_addr};
		end
		arp_rd_s1 <= arp_mem[scan_idx_q[AAW-1:0]];
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cmd_q        <= '0;
			route_cnt_q  <= '0;
			arp_cnt_q    <= '0;
			scan_idx_q   <= '0;
			rd_vld_s1    <= 1'b0;
			found_q      <= 1'b0;
			best_mask_q  <= '0;
			best_hop_q   <= '0;
			best_iface_q <= '0;
			done_q       <= 1'b0;
			result_q     <= '0;
		end else begin
			done_q    <= 1'b0;
			rd_vld_s1 <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						cmd_q   <= cmd;
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					// Default: finish with a single result beat
					state_q <= S_IDLE;
					done_q  <= 1'b1;
					case (cmd_q.mode)
						MODE_ROUTE: begin
							if (route_full) begin
								result_q <= mk_result(ST_FULL, '0, '0, '0, '0);
							end else begin
								route_cnt_q <= route_cnt_q + 1'b1;
								result_q    <= mk_result(ST_LOADED, '0, '0, '0, '0);
							end
						end
						MODE_ARP: begin
							if (arp_full) begin
								result_q <= mk_result(ST_FULL, '0, '0, '0, '0);
							end else begin
								arp_cnt_q <= arp_cnt_q + 1'b1;
								result_q  <= mk_result(ST_LOADED, '0, '0, '0, '0);
							end
						end
						MODE_FWD: begin
							if (echo_hit) begin
								result_q <= mk_result(ST_ECHO, cmd_q.in_port, '0, '0, '0);
							end else if (!cmd_q.header_ok) begin
								result_q <= mk_result(ST_DROP, '0, '0, '0, '0);
							end else if (cmd_q.ttl_in <= 8'd1) begin
								result_q <= mk_result(ST_TIME_EXCEEDED, cmd_q.in_port,
									'0, '0, '0);
							end else begin
								// Hold the result and start the route scan
								done_q     <= 1'b0;
								scan_idx_q <= '0;
								found_q    <= 1'b0;
								state_q    <= S_RSCAN;
							end
						end
						default: begin
							result_q <= mk_result(ST_DROP, '0, '0, '0, '0);
						end
					endcase
				end
				S_RSCAN: begin
					if (rd_vld_s1 && cmp_eq && mask_better) begin
						found_q      <= 1'b1;
						best_mask_q  <= route_rd_s1.mask;
						best_hop_q   <= route_rd_s1.hop;
						best_iface_q <= route_rd_s1.iface;
					end
					if (route_issue) begin
						scan_idx_q <= scan_idx_q + 1'b1;
						rd_vld_s1  <= 1'b1;
					end else if (!rd_vld_s1) begin
						if (!found_q) begin
							result_q <= mk_result(ST_UNREACHABLE, cmd_q.in_port, '0, '0, '0);
							done_q   <= 1'b1;
							state_q  <= S_IDLE;
						end else begin
							scan_idx_q <= '0;
							state_q    <= S_ASCAN;
						end
					end
				end
				S_ASCAN: begin
					if (rd_vld_s1 && cmp_eq) begin
						// First matching ARP entry wins; drop the read in flight
						result_q <= mk_result(ST_FORWARD, best_iface_q, best_hop_q,
							arp_rd_s1.mac, cmd_q.ttl_in - 8'd1);
						done_q   <= 1'b1;
						state_q  <= S_IDLE;
					end else if (arp_issue) begin
						scan_idx_q <= scan_idx_q + 1'b1;
						rd_vld_s1  <= 1'b1;
					end else if (!rd_vld_s1) begin
						result_q <= mk_result(ST_ARP_MISS, best_iface_q, best_hop_q, '0, '0);
						done_q   <= 1'b1;
						state_q  <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTH
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result beat issued without a command in progress");

	a_accept_goes_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted command did not raise busy");

	a_route_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		route_cnt_q <= RCW'(ROUTE_ENTRIES))
		else $error("route fill count beyond table depth");

	a_arp_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		arp_cnt_q <= ACW'(ARP_ENTRIES))
		else $error("ARP fill count beyond cache depth");

	a_forward_ttl: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (result.status == ST_FORWARD)) |-> (result.ttl_out != 8'd0))
		else $error("forwarded beat with expired TTL");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RSCAN) |-> (scan_idx_q <= SIW'(route_cnt_q)))
		else $error("route scan index ran past the fill count");
`endif

endmodule

// File: sim/tb_top.sv
// tb_top: self-checking bench for the IPv4 forwarding decision block.
// Drives directed and random command beats and checks each result beat against a local predictor.
// Depends on ipv4fd_pkg and ipv4_forwarding_decision_top.
module tb_top
	import ipv4fd_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	// Mode three carries no name in the package; the block must drop it
	localparam logic [1:0] MODE_IGNORED = 2'd3;
	// Longest stretch with no beat on any channel before the run is declared hung
	localparam int QUIET_LIMIT  = 4000;
	// Hold after the last result to catch stray done pulses
	localparam int DRAIN_CYCLES = 2 * (DEF_ROUTE_ENTRIES + DEF_ARP_ENTRIES + 5);
	localparam int REPORT_LIMIT = 10;
	localparam int HOP_POOL     = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PORT0_IP,
		REG_PORT1_IP,
		REG_PORT2_IP,
		REG_PORT3_IP
	} cfg_reg_e;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	cmd_t                 cmd;
	logic                 done;
	result_t              result;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [31:0]          cfg_data;

	// Local copy of the block state, advanced as each command beat is accepted
	logic [31:0] iface_ip  [DEF_NUM_PORTS];
	logic [31:0] rt_prefix [DEF_ROUTE_ENTRIES];
	logic [31:0] rt_mask   [DEF_ROUTE_ENTRIES];
	logic [31:0] rt_hop    [DEF_ROUTE_ENTRIES];
	logic [1:0]  rt_iface  [DEF_ROUTE_ENTRIES];
	logic [31:0] arp_ip    [DEF_ARP_ENTRIES];
	logic [47:0] arp_mac   [DEF_ARP_ENTRIES];
	int          rt_count  = 0;
	int          arp_count = 0;

	// Small set of next hops shared by routes and ARP replies so lookups resolve
	logic [31:0] hop_pool [HOP_POOL];

	result_t pending_decisions [$];
	int      mismatches   = 0;
	int      quiet_cycles = 0;
	int      idle_pct     = 0;

	always #1 clk = ~clk;

	ipv4_forwarding_decision_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.cmd       (cmd),
		.done      (done),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Work out the decision for one command and apply its table update.
	function automatic result_t decide_forwarding(cmd_t c);
		result_t r;
		int      i;
		int      best;
		bit      found;
		r = '0;
		best = 0;
		found = 1'b0;
		case (c.mode)
			MODE_ROUTE: begin
				if (rt_count >= DEF_ROUTE_ENTRIES) begin
					r.status = ST_FULL;
				end else begin
					rt_prefix[rt_count] = c.address;
					rt_mask[rt_count] = c.mask;
					rt_hop[rt_count] = c.hop_addr;
					rt_iface[rt_count] = c.route_port;
					rt_count++;
					r.status = ST_LOADED;
				end
			end
			MODE_ARP: begin
				if (arp_count >= DEF_ARP_ENTRIES) begin
					r.status = ST_FULL;
				end else begin
					arp_ip[arp_count] = c.address;
					arp_mac[arp_count] = c.mac_addr;
					arp_count++;
					r.status = ST_LOADED;
				end
			end
			MODE_FWD: begin
				// Echo to the arrival port's own address wins over every other check
				if (c.in_port < DEF_NUM_PORTS && iface_ip[c.in_port] == c.address &&
						c.protocol == ICMP_PROTO && c.icmp_kind == ICMP_ECHO_REQUEST) begin
					r.status = ST_ECHO;
					r.out_port = c.in_port;
					return r;
				end
				if (!c.header_ok) begin
					r.status = ST_DROP;
					return r;
				end
				if (c.ttl_in <= 8'd1) begin
					r.status = ST_TIME_EXCEEDED;
					r.out_port = c.in_port;
					return r;
				end
				// Longest mask wins; a strict compare keeps the earlier of equal masks
				for (i = 0; i < rt_count; i++) begin
					if ((c.address & rt_mask[i]) == rt_prefix[i] &&
							(!found || rt_mask[i] > rt_mask[best])) begin
						best = i;
						found = 1'b1;
					end
				end
				if (!found) begin
					r.status = ST_UNREACHABLE;
					r.out_port = c.in_port;
					return r;
				end
				r.out_port = rt_iface[best];
				r.hop_ip = rt_hop[best];
				// First ARP entry holding the next hop supplies the MAC
				for (i = 0; i < arp_count; i++) begin
					if (arp_ip[i] == rt_hop[best]) begin
						r.status = ST_FORWARD;
						r.hop_mac = arp_mac[i];
						r.ttl_out = c.ttl_in - 8'd1;
						return r;
					end
				end
				r.status = ST_ARP_MISS;
			end
			default: r.status = ST_DROP;
		endcase
		return r;
	endfunction

	// Fill every field with noise; builders then set what the mode reads.
	function automatic cmd_t random_fill();
		logic [191:0] bits;
		bits = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
		return cmd_t'(bits[$bits(cmd_t)-1:0]);
	endfunction

	function automatic cmd_t fwd_cmd(logic [31:0] dst, logic [1:0] port, logic [7:0] ttl,
			logic [7:0] proto, logic [7:0] kind, logic hdr_ok);
		cmd_t c;
		c = random_fill();
		c.mode = MODE_FWD;
		c.address = dst;
		c.in_port = port;
		c.ttl_in = ttl;
		c.protocol = proto;
		c.icmp_kind = kind;
		c.header_ok = hdr_ok;
		return c;
	endfunction

	function automatic cmd_t route_cmd(logic [31:0] prefix, logic [31:0] mask,
			logic [31:0] hop, logic [1:0] port);
		cmd_t c;
		c = random_fill();
		c.mode = MODE_ROUTE;
		c.address = prefix;
		c.mask = mask;
		c.hop_addr = hop;
		c.route_port = port;
		return c;
	endfunction

	function automatic cmd_t arp_cmd(logic [31:0] ip, logic [47:0] mac);
		cmd_t c;
		c = random_fill();
		c.mode = MODE_ARP;
		c.address = ip;
		c.mac_addr = mac;
		return c;
	endfunction

	function automatic logic [31:0] pick_hop();
		if ($urandom_range(0, 99) < 85)
			return hop_pool[$urandom_range(0, HOP_POOL - 1)];
		return $urandom;
	endfunction

	function automatic cmd_t random_route_cmd();
		int          pick;
		int          len;
		int          j;
		logic [31:0] m;
		pick = $urandom_range(0, 99);
		len = $urandom_range(1, 32);
		m = 32'hFFFF_FFFF << (32 - len);
		if (pick < 15 && rt_count > 0) begin
			// reuse an existing network so equal masks compete
			j = $urandom_range(0, rt_count - 1);
			return route_cmd(rt_prefix[j], rt_mask[j], pick_hop(), 2'($urandom_range(0, 3)));
		end
		if (pick < 35)
			// arbitrary mask and prefix, including bits outside the mask
			return route_cmd($urandom, $urandom, pick_hop(), 2'($urandom_range(0, 3)));
		return route_cmd($urandom & m, m, pick_hop(), 2'($urandom_range(0, 3)));
	endfunction

	function automatic cmd_t random_arp_cmd();
		logic [63:0] mac;
		mac = {$urandom, $urandom};
		return arp_cmd(pick_hop(), mac[47:0]);
	endfunction

	function automatic cmd_t random_fwd_cmd();
		cmd_t        c;
		int          pick;
		int          j;
		logic [31:0] dst;
		logic [7:0]  ttl;
		logic        hdr_ok;
		pick = $urandom_range(0, 99);
		if (pick < 12)
			// echo request to some interface address, arriving on any port
			return fwd_cmd(iface_ip[$urandom_range(0, DEF_NUM_PORTS - 1)],
				2'($urandom_range(0, 3)), 8'($urandom), ICMP_PROTO, ICMP_ECHO_REQUEST,
				1'($urandom_range(0, 1)));
		if (pick < 80 && rt_count > 0) begin
			// land inside a loaded network
			j = $urandom_range(0, rt_count - 1);
			dst = (rt_prefix[j] & rt_mask[j]) | ($urandom & ~rt_mask[j]);
		end else if (pick < 86) begin
			dst = iface_ip[$urandom_range(0, DEF_NUM_PORTS - 1)];
		end else begin
			dst = $urandom;
		end
		ttl = ($urandom_range(0, 99) < 8) ? 8'($urandom_range(0, 1)) : 8'($urandom_range(2, 255));
		hdr_ok = ($urandom_range(0, 99) >= 8);
		c = fwd_cmd(dst, 2'($urandom_range(0, 3)), ttl, 8'($urandom), 8'($urandom), hdr_ok);
		if ($urandom_range(0, 99) < 10) begin
			c.protocol = ICMP_PROTO;
			c.icmp_kind = ICMP_ECHO_REQUEST;
		end
		return c;
	endfunction

	// Offer one command beat, sometimes after a random idle burst, and hold it until taken.
	// Start is left high on return so back-to-back beats need not raise it again.
	task automatic send_cmd(cmd_t c);
		int gap;
		gap = ($urandom_range(0, 99) < idle_pct) ? $urandom_range(1, 18) : 0;
		@(negedge clk);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start <= 1'b1;
		cmd <= c;
		forever begin
			@(posedge clk);
			if (!busy)
				break;
		end
		pending_decisions.push_back(decide_forwarding(c));
	endtask

	// Drop start and wait until every decision has come back.
	task automatic settle();
		@(negedge clk);
		start <= 1'b0;
		while (pending_decisions.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_port_ip(cfg_reg_e idx, logic [31:0] ip);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= ip;
		forever begin
			@(posedge clk);
			if (cfg_ready)
				break;
		end
		iface_ip[idx] = ip;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_port_addresses(logic [31:0] ip0, logic [31:0] ip1,
			logic [31:0] ip2, logic [31:0] ip3);
		settle();
		write_port_ip(REG_PORT0_IP, ip0);
		write_port_ip(REG_PORT1_IP, ip1);
		write_port_ip(REG_PORT2_IP, ip2);
		write_port_ip(REG_PORT3_IP, ip3);
	endtask

	// Hand-picked beats: every mode, decision order, ties and the address extremes.
	task automatic test_directed();
		cmd_t c;
		// port 0 owns an address inside a route loaded below; 1 and 2 sit at the extremes
		set_port_addresses(32'h0A01_0201, 32'hFFFF_FFFF, 32'h0000_0000, 32'hC0A8_0101);
		c = random_fill();
		c.mode = MODE_IGNORED;
		send_cmd(c);
		// empty table: nothing routes
		send_cmd(fwd_cmd(32'h0808_0808, 2'd0, 8'd64, 8'd6, 8'd0, 1'b1));
		// echo wins over a bad header and a dead TTL
		send_cmd(fwd_cmd(32'h0A01_0201, 2'd0, 8'd0, ICMP_PROTO, ICMP_ECHO_REQUEST, 1'b0));
		send_cmd(fwd_cmd(32'hFFFF_FFFF, 2'd1, 8'd255, ICMP_PROTO, ICMP_ECHO_REQUEST, 1'b1));
		send_cmd(fwd_cmd(32'h0000_0000, 2'd2, 8'd1, ICMP_PROTO, ICMP_ECHO_REQUEST, 1'b1));
		// port 3's address arriving on port 0 is not local there
		send_cmd(fwd_cmd(32'hC0A8_0101, 2'd0, 8'd64, ICMP_PROTO, ICMP_ECHO_REQUEST, 1'b1));
		// ICMP that is not an echo request, bad header
		send_cmd(fwd_cmd(32'h0A01_0201, 2'd0, 8'd64, ICMP_PROTO, 8'd0, 1'b0));
		// bad header beats a dead TTL
		send_cmd(fwd_cmd(32'h0A01_0909, 2'd3, 8'd0, 8'd6, 8'd0, 1'b0));
		send_cmd(fwd_cmd(32'h0808_0808, 2'd3, 8'd0, 8'd17, 8'd0, 1'b1));
		send_cmd(fwd_cmd(32'h0808_0808, 2'd2, 8'd1, 8'd17, 8'd0, 1'b1));
		// /16, then two equal /24s where the earlier must win, then a host route
		send_cmd(route_cmd(32'h0A01_0000, 32'hFFFF_0000, 32'h0A00_00FE, 2'd1));
		send_cmd(route_cmd(32'h0A01_0200, 32'hFFFF_FF00, 32'h0A00_00FD, 2'd2));
		send_cmd(route_cmd(32'h0A01_0200, 32'hFFFF_FF00, 32'h0A00_00FC, 2'd3));
		send_cmd(route_cmd(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0A00_00FB, 2'd3));
		// duplicate ARP entry: the first one must be used
		send_cmd(arp_cmd(32'h0A00_00FD, 48'hFFFF_FFFF_FFFF));
		send_cmd(arp_cmd(32'h0A00_00FE, 48'h0000_0000_0000));
		send_cmd(arp_cmd(32'h0A00_00FD, 48'h1234_5678_9ABC));
		send_cmd(fwd_cmd(32'h0A01_024D, 2'd0, 8'd255, 8'd6, 8'd0, 1'b1));
		send_cmd(fwd_cmd(32'h0A01_0909, 2'd1, 8'd2, 8'd6, 8'd0, 1'b1));
		// host route with no ARP entry; echo to port 1's address arriving on port 2
		send_cmd(fwd_cmd(32'hFFFF_FFFF, 2'd2, 8'd64, ICMP_PROTO, ICMP_ECHO_REQUEST, 1'b1));
		// non-echo traffic to a local address goes through forwarding
		send_cmd(fwd_cmd(32'h0A01_0201, 2'd0, 8'd64, 8'd6, ICMP_ECHO_REQUEST, 1'b1));
		send_cmd(fwd_cmd(32'h0B00_0000, 2'd1, 8'd64, 8'd6, 8'd0, 1'b1));
		send_cmd(cmd_t'('1));
	endtask

	// Mixed loads and lookups; idling changes every few dozen beats when bursty.
	task automatic test_random_traffic(int n, int route_pct, int arp_pct, bit bursty);
		int k;
		int roll;
		cmd_t c;
		idle_pct = 0;
		for (k = 0; k < n; k++) begin
			if (bursty && k % 40 == 0) begin
				roll = $urandom_range(0, 2);
				idle_pct = (roll == 0) ? 0 : (roll == 1) ? 10 : 40;
			end
			roll = $urandom_range(0, 99);
			if (roll < route_pct) begin
				send_cmd(random_route_cmd());
			end else if (roll < route_pct + arp_pct) begin
				send_cmd(random_arp_cmd());
			end else if (roll < route_pct + arp_pct + 2) begin
				c = random_fill();
				c.mode = MODE_IGNORED;
				send_cmd(c);
			end else begin
				send_cmd(random_fwd_cmd());
			end
		end
	endtask

	// Fill both tables to the brim, then push past the end of each.
	task automatic test_table_full();
		int k;
		idle_pct = 10;
		// default route: from here on every lookup finds a route
		if (rt_count < DEF_ROUTE_ENTRIES)
			send_cmd(route_cmd('0, '0, pick_hop(), 2'($urandom_range(0, 3))));
		while (rt_count < DEF_ROUTE_ENTRIES) begin
			send_cmd(random_route_cmd());
			if ($urandom_range(0, 9) == 0)
				send_cmd(random_fwd_cmd());
		end
		while (arp_count < DEF_ARP_ENTRIES)
			send_cmd(random_arp_cmd());
		for (k = 0; k < 6; k++) begin
			send_cmd(random_route_cmd());
			send_cmd(random_arp_cmd());
		end
	endtask

	task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
		if (got !== want) begin
			mismatches++;
			if (mismatches <= REPORT_LIMIT)
				$display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
		end
	endtask

	// Compare each result beat against the oldest pending decision.
	always @(posedge clk) begin : check_results
		result_t want;
		if (arst_n && done === 1'b1) begin
			if (pending_decisions.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("%0t: result beat with no decision pending, got %h",
						$time, result);
			end else begin
				want = pending_decisions.pop_front();
				check_field("status", 64'(want.status), 64'(result.status));
				check_field("out_port", 64'(want.out_port), 64'(result.out_port));
				check_field("hop_ip", 64'(want.hop_ip), 64'(result.hop_ip));
				check_field("hop_mac", 64'(want.hop_mac), 64'(result.hop_mac));
				check_field("ttl_out", 64'(want.ttl_out), 64'(result.ttl_out));
			end
		end
	end

	// Count cycles with no beat on any channel; a hung block ends the run.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("tb_top: FAIL");
			$finish;
		end
	end

	initial begin
		int p;
		arst_n = 1'b0;
		start = 1'b0;
		cmd = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		for (p = 0; p < DEF_NUM_PORTS; p++)
			iface_ip[p] = '0;
		// keep the address extremes among the next hops
		hop_pool[0] = 32'h0000_0000;
		hop_pool[1] = 32'hFFFF_FFFF;
		for (p = 2; p < HOP_POOL; p++)
			hop_pool[p] = $urandom;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_random_traffic(250, 25, 9, 1'b1);
		// move the interface addresses: extremes plus one inside a loaded network
		set_port_addresses(32'hFFFF_FFFF, 32'h0000_0000,
			(rt_prefix[0] & rt_mask[0]) | 32'h1, $urandom);
		test_random_traffic(250, 20, 9, 1'b1);
		test_table_full();
		set_port_addresses($urandom, $urandom, $urandom, hop_pool[2]);
		// closing stretch runs back to back against full tables
		test_random_traffic(120, 4, 4, 1'b0);

		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

endmodule

// File: filelist.f
rtl/ipv4fd_pkg.sv
rtl/ipv4_forwarding_decision_top.sv
sim/tb_top.sv
